// ----- src/amrp_pkg.sv -----
// Shared types, character codes and match helpers for the modem receive parser.
`default_nettype none

package amrp_pkg;

  localparam int HEADER_MAX_DEF  = 10;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Bytes kept at line start: enough for the longest data header before ':'.
  localparam int HEAD_KEEP = 9;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;

  localparam logic [2:0] CONNECT_LEN = 3'd7;
  localparam logic [2:0] CLOSED_LEN  = 3'd6;

  localparam logic signed [4:0] LINK_NONE = -5'sd1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_CONNECT = 2'd1,
    KIND_CLOSE   = 2'd2
  } kind_t;

  // Byte with its classification, as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       is_digit;
    logic       is_cr;
    logic       is_lf;
    logic       is_colon;
  } byte_class_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic [6:0] times_ten(input logic [3:0] d);
    return {d, 3'b000} + {2'b00, d, 1'b0};
  endfunction

  // Progress on CONNECT after byte c, given p bytes matched (7 = found).
  function automatic logic [2:0] connect_step(input logic [2:0] p, input logic [7:0] c);
    logic [7:0] want;
    case (p)
      3'd0:    want = CH_C;
      3'd1:    want = CH_O;
      3'd2:    want = CH_N;
      3'd3:    want = CH_N;
      3'd4:    want = CH_E;
      3'd5:    want = CH_C;
      3'd6:    want = CH_T;
      default: want = 8'h00;
    endcase
    if (p >= CONNECT_LEN) return p;
    if (c == want) return p + 3'd1;
    // "CONNEC" ends in "C", so a following 'O' resumes at "CO"
    if (p == 3'd6 && c == CH_O) return 3'd2;
    if (c == CH_C) return 3'd1;
    return 3'd0;
  endfunction

  // Progress on CLOSED after byte c, given p bytes matched (6 = found).
  function automatic logic [2:0] close_step(input logic [2:0] p, input logic [7:0] c);
    logic [7:0] want;
    case (p)
      3'd0:    want = CH_C;
      3'd1:    want = CH_L;
      3'd2:    want = CH_O;
      3'd3:    want = CH_S;
      3'd4:    want = CH_E;
      3'd5:    want = CH_D;
      default: want = 8'h00;
    endcase
    if (p >= CLOSED_LEN) return p;
    if (c == want) return p + 3'd1;
    if (c == CH_C) return 3'd1;
    return 3'd0;
  endfunction

endpackage

`default_nettype wire

// ----- src/amrp_front.sv -----
// Front end: classify each incoming byte and push it into the queue.
`default_nettype none

module amrp_front
  import amrp_pkg::*;
(
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        q_full,
  output logic             q_push,
  output byte_class_t      q_wdata
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.data     = in_rx_byte;
    q_wdata.is_digit = is_digit(in_rx_byte);
    q_wdata.is_cr    = (in_rx_byte == CH_CR);
    q_wdata.is_lf    = (in_rx_byte == CH_LF);
    q_wdata.is_colon = (in_rx_byte == CH_COLON);
  end

endmodule

`default_nettype wire

// ----- src/amrp_queue.sv -----
// Short flop-based queue between the front end and the parser.
`default_nettype none

module amrp_queue
  import amrp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int WIDTH = $bits(byte_class_t)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  rvalid,
  output logic [WIDTH-1:0]      rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full   = (count_r == CNT_W'(DEPTH));
  assign rvalid = (count_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- src/amrp_back.sv -----
// Back end: line parser, payload capture and result register.
`default_nettype none

module amrp_back
  import amrp_pkg::*;
#(
  parameter int HEADER_MAX = HEADER_MAX_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire byte_class_t        q_rdata,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_result_kind,
  output logic signed [4:0]       out_link_id,
  output logic [7:0]              out_data_byte,
  output logic                    out_last_byte,
  output logic                    out_connected
);

  localparam int LL_W = $clog2(HEADER_MAX + 1);

  // line state
  logic [7:0]        head_r [HEAD_KEEP];
  logic [LL_W-1:0]   ll_r, ll_nxt;
  logic [7:0]        prev1_r, prev1_nxt;
  logic [7:0]        prev2_r, prev2_nxt;
  logic [2:0]        conn_prog_r, conn_prog_nxt;
  logic [2:0]        close_prog_r, close_prog_nxt;
  logic signed [4:0] conn_link_r, conn_link_nxt;
  logic signed [4:0] close_link_r, close_link_nxt;
  // capture state
  logic [6:0]        rem_r, rem_nxt;
  logic signed [4:0] plink_r, plink_nxt;
  logic              link_up_r, link_up_nxt;
  // result register
  logic              out_valid_r, out_valid_nxt;
  kind_t             kind_r, kind_nxt;
  logic signed [4:0] olink_r, olink_nxt;
  logic [7:0]        odata_r, odata_nxt;
  logic              olast_r, olast_nxt;
  logic              oconn_r, oconn_nxt;

  logic              res_valid;
  logic              head_we;
  logic [7:0]        c;
  logic [2:0]        conn_p, close_p;
  logic signed [4:0] word_link;
  logic              prefix_ok;
  logic              hdr;
  logic [6:0]        hdr_len;
  logic signed [4:0] hdr_link;

  assign c     = q_rdata.data;
  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  assign conn_p    = connect_step(conn_prog_r, c);
  assign close_p   = close_step(close_prog_r, c);
  assign word_link = (prev1_r == CH_COMMA && is_digit(prev2_r))
                     ? $signed({1'b0, prev2_r[3:0]}) : LINK_NONE;

  assign prefix_ok = head_r[0] == CH_PLUS && head_r[1] == CH_I && head_r[2] == CH_P
                     && head_r[3] == CH_D && head_r[4] == CH_COMMA;

  // Header decode; head entries below ll_r are always from this line.
  always_comb begin
    hdr      = 1'b0;
    hdr_len  = '0;
    hdr_link = LINK_NONE;
    if (q_rdata.is_colon && prefix_ok) begin
      if (ll_r == LL_W'(6) && is_digit(head_r[5])) begin
        hdr     = 1'b1;
        hdr_len = {3'b000, head_r[5][3:0]};
      end else if (ll_r == LL_W'(7) && is_digit(head_r[5]) && is_digit(head_r[6])) begin
        hdr     = 1'b1;
        hdr_len = times_ten(head_r[5][3:0]) + {3'b000, head_r[6][3:0]};
      end else if (ll_r == LL_W'(8) && is_digit(head_r[5]) && head_r[6] == CH_COMMA
                   && is_digit(head_r[7])) begin
        hdr      = 1'b1;
        hdr_link = $signed({1'b0, head_r[5][3:0]});
        hdr_len  = {3'b000, head_r[7][3:0]};
      end else if (ll_r == LL_W'(9) && is_digit(head_r[5]) && head_r[6] == CH_COMMA
                   && is_digit(head_r[7]) && is_digit(head_r[8])) begin
        hdr      = 1'b1;
        hdr_link = $signed({1'b0, head_r[5][3:0]});
        hdr_len  = times_ten(head_r[7][3:0]) + {3'b000, head_r[8][3:0]};
      end
    end
  end

  always_comb begin
    ll_nxt         = ll_r;
    prev1_nxt      = prev1_r;
    prev2_nxt      = prev2_r;
    conn_prog_nxt  = conn_prog_r;
    close_prog_nxt = close_prog_r;
    conn_link_nxt  = conn_link_r;
    close_link_nxt = close_link_r;
    rem_nxt        = rem_r;
    plink_nxt      = plink_r;
    link_up_nxt    = link_up_r;
    head_we        = 1'b0;
    res_valid      = 1'b0;
    kind_nxt       = kind_r;
    olink_nxt      = olink_r;
    odata_nxt      = odata_r;
    olast_nxt      = olast_r;

    if (q_pop) begin
      if (rem_r != '0) begin
        // capture: pass the byte through untouched
        rem_nxt   = rem_r - 7'd1;
        res_valid = 1'b1;
        kind_nxt  = KIND_PAYLOAD;
        olink_nxt = plink_r;
        odata_nxt = c;
        olast_nxt = (rem_r == 7'd1);
      end else if (prev1_r == CH_CR && q_rdata.is_lf) begin
        // end of line: CONNECT wins over CLOSED
        if (conn_prog_r >= CONNECT_LEN) begin
          link_up_nxt = 1'b1;
          res_valid   = 1'b1;
          kind_nxt    = KIND_CONNECT;
          olink_nxt   = conn_link_r;
        end else if (close_prog_r >= CLOSED_LEN) begin
          link_up_nxt = 1'b0;
          res_valid   = 1'b1;
          kind_nxt    = KIND_CLOSE;
          olink_nxt   = close_link_r;
        end
        odata_nxt = '0;
        olast_nxt = 1'b0;
      end else begin
        if (conn_prog_r < CONNECT_LEN && conn_p == 3'd1) begin
          conn_link_nxt = word_link;
        end
        conn_prog_nxt = conn_p;
        if (close_prog_r < CLOSED_LEN && close_p == 3'd1) begin
          close_link_nxt = word_link;
        end
        close_prog_nxt = close_p;
        if (hdr) begin
          rem_nxt   = (hdr_len == '0) ? 7'd1 : hdr_len;
          plink_nxt = hdr_link;
        end else begin
          if (ll_r < LL_W'(HEADER_MAX)) begin
            head_we = 1'b1;
            ll_nxt  = ll_r + LL_W'(1);
          end
          prev2_nxt = prev1_r;
          prev1_nxt = c;
        end
      end

      // restart the line after a line end, a header or the last payload byte
      if ((rem_r == 7'd1) || (rem_r == '0 && prev1_r == CH_CR && q_rdata.is_lf)
          || (rem_r == '0 && hdr)) begin
        ll_nxt         = '0;
        prev1_nxt      = '0;
        prev2_nxt      = '0;
        conn_prog_nxt  = '0;
        close_prog_nxt = '0;
        conn_link_nxt  = LINK_NONE;
        close_link_nxt = LINK_NONE;
      end
    end

    oconn_nxt = res_valid ? link_up_nxt : oconn_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ll_r         <= '0;
      prev1_r      <= '0;
      prev2_r      <= '0;
      conn_prog_r  <= '0;
      close_prog_r <= '0;
      conn_link_r  <= LINK_NONE;
      close_link_r <= LINK_NONE;
      rem_r        <= '0;
      plink_r      <= LINK_NONE;
      link_up_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      ll_r         <= ll_nxt;
      prev1_r      <= prev1_nxt;
      prev2_r      <= prev2_nxt;
      conn_prog_r  <= conn_prog_nxt;
      close_prog_r <= close_prog_nxt;
      conn_link_r  <= conn_link_nxt;
      close_link_r <= close_link_nxt;
      rem_r        <= rem_nxt;
      plink_r      <= plink_nxt;
      link_up_r    <= link_up_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    olink_r <= olink_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
    oconn_r <= oconn_nxt;
  end

  for (genvar i = 0; i < HEAD_KEEP; i++) begin : g_head
    always_ff @(posedge clk) begin
      if (head_we && ll_r == LL_W'(i)) begin
        head_r[i] <= c;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_link_id     = olink_r;
  assign out_data_byte   = odata_r;
  assign out_last_byte   = olast_r;
  assign out_connected   = oconn_r;

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 7'd99)
    else $error("capture count out of range");

  a_last_ends_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && rem_r == 7'd1) |=> (rem_r == '0 && ll_r == '0))
    else $error("capture did not end after last byte");

  a_event_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r != KIND_PAYLOAD) |-> (odata_r == '0 && !olast_r))
    else $error("event beat carries payload fields");

  a_connect_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_CONNECT) |-> oconn_r)
    else $error("connect event without connected flag");

endmodule

`default_nettype wire

// ----- src/at_modem_receive_parser.sv -----
// Top level of the modem receive parser: front end, queue and parser back end.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  in_rx_byte
//   out_      output     out_valid/out_stall  out_result_kind, out_link_id,
//                                             out_data_byte, out_last_byte,
//                                             out_connected
//
// Takes one byte beat per cycle while the queue is not full; a beat that yields a
// result passes a queue slot, then the result register, before it shows on out_.
// The front end stalls only when the queue is full; the parser pops one entry
// per cycle while the result register is empty or being taken.
// A stalled result register holds its beat and halts the parser; the queue keeps
// absorbing input until it fills.
// Reset (rst_n low, synchronous) clears line, capture and connect state at once.
`default_nettype none

module at_modem_receive_parser
  import amrp_pkg::*;
#(
  parameter int HEADER_MAX  = HEADER_MAX_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_result_kind,
  output logic signed [4:0]       out_link_id,
  output logic [7:0]              out_data_byte,
  output logic                    out_last_byte,
  output logic                    out_connected
);

  logic        q_full;
  logic        q_push;
  byte_class_t q_wdata;
  logic        q_pop;
  logic        q_valid;
  byte_class_t q_rdata;

  // classify and enqueue
  amrp_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  // decouple intake from the parser
  amrp_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(byte_class_t))
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  // parse lines, capture payload, drive result beats
  amrp_back #(
    .HEADER_MAX (HEADER_MAX)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_link_id     (out_link_id),
    .out_data_byte   (out_data_byte),
    .out_last_byte   (out_last_byte),
    .out_connected   (out_connected)
  );

endmodule

`default_nettype wire

// ----- verif/at_modem_receive_parser_tb.sv -----
// Self-checking testbench for the modem receive parser: byte driver, result monitor, predictor.
`default_nettype none

module at_modem_receive_parser_tb;
  import amrp_pkg::*;

  localparam int LINE_KEEP   = HEADER_MAX_DEF;
  localparam int PHASE_BYTES = 225;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_CAP   = 30;

  // Words searched for in a line, first byte in the low bits.
  localparam logic [55:0] CONNECT_WORD = "TCENNOC";
  localparam logic [55:0] CLOSED_WORD  = {8'h00, "DESOLC"};

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [4:0] link;
    logic [7:0]        data;
    logic              last;
    logic              conn;
  } parse_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [1:0]        out_result_kind;
  logic signed [4:0] out_link_id;
  logic [7:0]        out_data_byte;
  logic              out_last_byte;
  logic              out_connected;

  // Flow-control knobs, percent of cycles; set per phase by the sequencer.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  logic [7:0]    rx_bytes_pending[$];
  parse_result_t expected_results[$];
  parse_result_t want_r;

  int error_count   = 0;
  int bytes_queued  = 0;
  int bytes_sent    = 0;
  int payload_beats = 0;
  int connect_beats = 0;
  int close_beats   = 0;
  int cycle_count   = 0;

  // Predictor state: current line, word search, capture and connection flag.
  logic [7:0]        head_bytes[0:LINE_KEEP-1];
  int                head_count;
  logic [15:0]       last_two;
  int                connect_seen;
  int                close_seen;
  logic signed [4:0] connect_link;
  logic signed [4:0] close_link;
  int                capture_left;
  logic signed [4:0] capture_link;
  logic              link_flag;

  at_modem_receive_parser u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_link_id     (out_link_id),
    .out_data_byte   (out_data_byte),
    .out_last_byte   (out_last_byte),
    .out_connected   (out_connected)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic is_decimal(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic int digit_val(input logic [7:0] b);
    return int'(b) - 48;
  endfunction

  // Longest prefix of the word that ends with byte c, given p bytes already matched.
  // A full match sticks until the line ends.
  function automatic int word_progress(input logic [55:0] w, input int wlen, input int p,
                                       input logic [7:0] c);
    int  k;
    int  i;
    logic ok;
    if (p >= wlen) return p;
    for (k = p + 1; k >= 1; k--) begin
      ok = (w[8*(k-1) +: 8] == c);
      for (i = 0; i + 1 < k; i++)
        if (w[8*i +: 8] != w[8*(p-k+1+i) +: 8]) ok = 1'b0;
      if (ok) return k;
    end
    return 0;
  endfunction

  // Link of a word that starts now: "<digit>," right in front of it, else none.
  function automatic logic signed [4:0] link_in_front();
    if (last_two[7:0] == CH_COMMA && is_decimal(last_two[15:8]))
      return {1'b0, last_two[11:8]};
    return LINK_NONE;
  endfunction

  task automatic restart_line();
    int i;
    for (i = 0; i < LINE_KEEP; i++) head_bytes[i] = 8'h00;
    head_count   = 0;
    last_two     = 16'h0000;
    connect_seen = 0;
    close_seen   = 0;
    connect_link = LINK_NONE;
    close_link   = LINK_NONE;
  endtask

  task automatic reset_predictor();
    restart_line();
    capture_left = 0;
    capture_link = LINK_NONE;
    link_flag    = 1'b0;
  endtask

  // Advance the predictor by one accepted byte; queue the result it causes, if any.
  task automatic predict_rx_byte(input logic [7:0] c);
    parse_result_t     r;
    int                p;
    int                n;
    int                len;
    logic signed [4:0] hlink;
    logic              hdr;
    logic              emit;
    r     = '0;
    len   = 0;
    hlink = LINK_NONE;
    hdr   = 1'b0;
    emit  = 1'b0;
    if (capture_left != 0) begin
      // Inside a frame: pass the byte through, nothing else is looked at.
      capture_left--;
      r.kind = KIND_PAYLOAD;
      r.link = capture_link;
      r.data = c;
      r.last = (capture_left == 0);
      r.conn = link_flag;
      if (capture_left == 0) restart_line();
      expected_results.push_back(r);
    end else if (last_two[7:0] == CH_CR && c == CH_LF) begin
      // Line end: CONNECT wins over CLOSED.
      if (connect_seen >= 7) begin
        link_flag = 1'b1;
        emit      = 1'b1;
        r.kind    = KIND_CONNECT;
        r.link    = connect_link;
      end else if (close_seen >= 6) begin
        link_flag = 1'b0;
        emit      = 1'b1;
        r.kind    = KIND_CLOSE;
        r.link    = close_link;
      end
      r.conn = link_flag;
      restart_line();
      if (emit) expected_results.push_back(r);
    end else begin
      p = word_progress(CONNECT_WORD, 7, connect_seen, c);
      if (connect_seen < 7 && p == 1) connect_link = link_in_front();
      connect_seen = p;
      p = word_progress(CLOSED_WORD, 6, close_seen, c);
      if (close_seen < 6 && p == 1) close_link = link_in_front();
      close_seen = p;

      n = head_count;
      if (c == CH_COLON && n >= 6 && n <= 9 && head_bytes[0] == CH_PLUS &&
          head_bytes[1] == CH_I && head_bytes[2] == CH_P && head_bytes[3] == CH_D &&
          head_bytes[4] == CH_COMMA) begin
        case (n)
          6: begin
            if (is_decimal(head_bytes[5])) begin
              hdr = 1'b1;
              len = digit_val(head_bytes[5]);
            end
          end
          7: begin
            if (is_decimal(head_bytes[5]) && is_decimal(head_bytes[6])) begin
              hdr = 1'b1;
              len = digit_val(head_bytes[5]) * 10 + digit_val(head_bytes[6]);
            end
          end
          8: begin
            if (is_decimal(head_bytes[5]) && head_bytes[6] == CH_COMMA &&
                is_decimal(head_bytes[7])) begin
              hdr   = 1'b1;
              hlink = {1'b0, head_bytes[5][3:0]};
              len   = digit_val(head_bytes[7]);
            end
          end
          default: begin
            if (is_decimal(head_bytes[5]) && head_bytes[6] == CH_COMMA &&
                is_decimal(head_bytes[7]) && is_decimal(head_bytes[8])) begin
              hdr   = 1'b1;
              hlink = {1'b0, head_bytes[5][3:0]};
              len   = digit_val(head_bytes[7]) * 10 + digit_val(head_bytes[8]);
            end
          end
        endcase
      end

      if (hdr) begin
        // Header done: arm capture, a zero length still takes one byte.
        restart_line();
        capture_left = (len == 0) ? 1 : len;
        capture_link = hlink;
      end else begin
        if (head_count < LINE_KEEP) begin
          head_bytes[head_count] = c;
          head_count++;
        end
        last_two = {last_two[7:0], c};
      end
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_byte(input logic [7:0] b);
    rx_bytes_pending.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // Mostly characters that feed the header and word search, now and then any byte.
  function automatic logic [7:0] noise_byte();
    string pool;
    pool = "CONETLSDIP+,:0159\r ";
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  function automatic logic [7:0] payload_byte();
    string pool;
    pool = "\r\n:+C";
    if ($urandom_range(7) == 0) return pool[$urandom_range(pool.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  function automatic string pick_word(input int sel);
    case (sel)
      0:       return "CONNECT";
      1:       return "CLOSED";
      2:       return "CONNECONNECT";
      3:       return "CLOCLOSED";
      4:       return "CLOSED CONNECT";
      5:       return "CONNEC";
      6:       return "CLOSE";
      7:       return "CCONNECT";
      8:       return "CONNECTCLOSED";
      default: return "COCONNECT";
    endcase
  endfunction

  // Data frame in one of the four header forms; broken ones turn into a plain line.
  task automatic add_frame(input logic broken);
    logic [7:0] hdr_q[$];
    string      bad;
    int         form;
    int         len;
    int         i;
    int         pos;
    bad  = "/;A,:+I";
    form = $urandom_range(3);
    if (form[0] == 1'b0)
      len = $urandom_range(9);
    else if ($urandom_range(19) == 0)
      len = $urandom_range(99);
    else
      len = $urandom_range(15);
    hdr_q = '{CH_PLUS, CH_I, CH_P, CH_D, CH_COMMA};
    if (form >= 2) begin
      hdr_q.push_back(8'(8'h30 + $urandom_range(9)));
      hdr_q.push_back(CH_COMMA);
    end
    if (form[0] == 1'b1) hdr_q.push_back(8'(8'h30 + len / 10));
    hdr_q.push_back(8'(8'h30 + len % 10));
    hdr_q.push_back(CH_COLON);
    if (broken) begin
      if ($urandom_range(2) == 0) begin
        // Header not at line start.
        hdr_q.push_front(noise_byte());
      end else begin
        pos = $urandom_range(hdr_q.size() - 2);
        hdr_q[pos] = bad[$urandom_range(bad.len() - 1)];
      end
    end
    foreach (hdr_q[i]) push_byte(hdr_q[i]);
    for (i = 0; i < ((len == 0) ? 1 : len); i++) push_byte(payload_byte());
    if (broken) push_text("\r\n");
  endtask

  task automatic add_event_line();
    int i;
    int n;
    n = $urandom_range(4);
    for (i = 0; i < n; i++) push_byte(noise_byte());
    case ($urandom_range(3))
      1: begin
        push_byte(8'(8'h30 + $urandom_range(9)));
        push_byte(CH_COMMA);
      end
      2: begin
        push_byte(noise_byte());
        push_byte(CH_COMMA);
      end
      3: push_byte(8'(8'h30 + $urandom_range(9)));
      default: ;
    endcase
    push_text(pick_word($urandom_range(9)));
    n = $urandom_range(3);
    for (i = 0; i < n; i++) push_byte(noise_byte());
    if ($urandom_range(9) == 0) push_byte(CH_CR);
    else push_text("\r\n");
  endtask

  task automatic add_noise_line();
    int i;
    int n;
    n = $urandom_range(16);
    for (i = 0; i < n; i++) push_byte(noise_byte());
    push_text("\r\n");
  endtask

  task automatic fill_phase(input int target);
    int start;
    int pick;
    start = bytes_queued;
    while (bytes_queued - start < target) begin
      pick = $urandom_range(99);
      if (pick < 45)      add_frame(1'b0);
      else if (pick < 75) add_event_line();
      else if (pick < 90) add_frame(1'b1);
      else                add_noise_line();
    end
  endtask

  // Hold the sequencer until every queued byte is taken and every result is back.
  task automatic drain();
    while (rx_bytes_pending.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------- driver

  // Predict each beat as it is taken, then present the next byte or idle.
  // Hold the current beat while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_rx_byte(in_rx_byte);
        bytes_sent++;
      end
      if (rx_bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        in_rx_byte <= rx_bytes_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < PRINT_CAP)
      $display("MISMATCH at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // Compare each taken result beat with the oldest prediction; drive random stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat, kind", int'(out_result_kind), -1);
      end else begin
        want_r = expected_results.pop_front();
        if (out_result_kind !== want_r.kind)
          report_mismatch("result_kind", int'(out_result_kind), int'(want_r.kind));
        if (out_link_id !== want_r.link)
          report_mismatch("link_id", int'(out_link_id), int'(want_r.link));
        if (out_data_byte !== want_r.data)
          report_mismatch("data_byte", int'(out_data_byte), int'(want_r.data));
        if (out_last_byte !== want_r.last)
          report_mismatch("last_byte", int'(out_last_byte), int'(want_r.last));
        if (out_connected !== want_r.conn)
          report_mismatch("connected", int'(out_connected), int'(want_r.conn));
        case (want_r.kind)
          KIND_PAYLOAD: payload_beats++;
          KIND_CONNECT: connect_beats++;
          default:      close_beats++;
        endcase
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequencer

  initial begin
    reset_predictor();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero-length frame with an all-ones byte, linked CONNECT, plain CLOSED.
    push_text("+IPD,0:");
    push_byte(8'hFF);
    push_text("7,CONNECT\r\n");
    push_text("CLOSED\r\n");
    drain();

    // Phase 1: no idling on either side.
    fill_phase(PHASE_BYTES);
    drain();

    // Phase 2: sparse sender.
    send_idle_pct = 81;
    fill_phase(PHASE_BYTES);
    drain();

    // Phase 3: receiver stalls most cycles, sender at full rate.
    send_idle_pct = 0;
    stall_pct     = 81;
    fill_phase(PHASE_BYTES);
    drain();

    // Phase 4: both sides idle now and then.
    send_idle_pct = 29;
    stall_pct     = 29;
    fill_phase(PHASE_BYTES);
    drain();

    // Let the pipeline settle so a stray late beat is still caught.
    repeat (8) @(negedge clk);

    $display("Covered %0d received bytes over four flow-control phases:", bytes_sent);
    $display("  %0d payload beats, %0d connect and %0d close events checked",
             payload_beats, connect_beats, close_beats);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
